[hdl/ktl_pkg.sv]
// ----------------------------------------------------------------------------
// ktl_pkg
// Shared types, codes and character constants for the keyword token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package ktl_pkg;

    localparam longint unsigned SOURCE_BYTES_DEF = 64'd1048576;

    localparam int unsigned FW = 20;
    localparam logic [FW-1:0] POS_MAX = {FW{1'b1}};

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_NUM   = 2'd2;
    localparam logic [1:0] MODE_STR   = 2'd3;

    localparam logic [3:0] CL_IDENT  = 4'd0;
    localparam logic [3:0] CL_EQUAL  = 4'd1;
    localparam logic [3:0] CL_ADD    = 4'd2;
    localparam logic [3:0] CL_STRING = 4'd3;
    localparam logic [3:0] CL_NUMBER = 4'd4;
    localparam logic [3:0] CL_FN     = 4'd5;
    localparam logic [3:0] CL_LBRACE = 4'd6;
    localparam logic [3:0] CL_RBRACE = 4'd7;
    localparam logic [3:0] CL_RETURN = 4'd8;
    localparam logic [3:0] CL_LPAREN = 4'd9;
    localparam logic [3:0] CL_RPAREN = 4'd10;
    localparam logic [3:0] CL_ERROR  = 4'd11;

    localparam logic [2:0] KW_NONE     = 3'd0;
    localparam logic [2:0] KW_F        = 3'd1;
    localparam logic [2:0] KW_R        = 3'd2;
    localparam logic [2:0] KW_RETU_R   = 3'd6;

    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;

    typedef struct packed {
        logic [3:0]    token_class;
        logic [FW-1:0] token_line;
        logic [FW-1:0] token_column;
        logic [FW-1:0] text_offset;
        logic [FW-1:0] text_length;
        logic          last_of_item;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // next expected byte of "return" given the bytes matched so far
    function automatic logic [7:0] kw_char(input logic [2:0] p);
        logic [7:0] ch;
        case (p)
            3'd2:    ch = CH_E;
            3'd3:    ch = CH_T;
            3'd4:    ch = CH_U;
            3'd5:    ch = CH_R;
            3'd6:    ch = CH_N;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] sym_class(input logic [7:0] c);
        logic [3:0] cls;
        case (c)
            CH_EQUAL:  cls = CL_EQUAL;
            CH_PLUS:   cls = CL_ADD;
            CH_LBRACE: cls = CL_LBRACE;
            CH_RBRACE: cls = CL_RBRACE;
            CH_LPAREN: cls = CL_LPAREN;
            CH_RPAREN: cls = CL_RPAREN;
            default:   cls = CL_ERROR;
        endcase
        return cls;
    endfunction

    function automatic t_result make_result(
        input logic [3:0]    cls,
        input logic [FW-1:0] line,
        input logic [FW-1:0] col,
        input logic [FW-1:0] off,
        input logic [FW-1:0] len
    );
        t_result r;
        r.token_class  = cls;
        r.token_line   = line;
        r.token_column = col;
        r.text_offset  = off;
        r.text_length  = len;
        r.last_of_item = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/keyword_token_lexer.sv]
// ----------------------------------------------------------------------------
// keyword_token_lexer
// Streaming lexer: one source byte per transfer, up to two tokens out.
// ----------------------------------------------------------------------------
//  channel | valid    | ready    | payload
//  --------+----------+----------+------------------------------------------
//  source  | i_valid  | o_ready  | i_source_byte, i_end_of_source
//  tokens  | o_valid  | i_ready  | o_token_class .. o_text_length,
//          |          |          | o_last_of_item
//
//  One byte per cycle; its tokens enter a four-entry result queue in the
//  same cycle and leave one per cycle. o_ready is high while the queue has
//  room for two results, so bytes flow at that rate unless the token side
//  stalls or bytes yield two tokens faster than they drain.
//  Synchronous reset empties the queue and returns the lexer to line 1,
//  column 1, offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_lexer #(
    parameter longint unsigned SOURCE_BYTES = ktl_pkg::SOURCE_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_source_byte,
    input  wire logic       i_end_of_source,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [3:0]      o_token_class,
    output logic [19:0]     o_token_line,
    output logic [19:0]     o_token_column,
    output logic [19:0]     o_text_offset,
    output logic [19:0]     o_text_length,
    output logic            o_last_of_item
);

    localparam int unsigned PW = $clog2(SOURCE_BYTES);
    localparam logic [PW-1:0] LAST = PW'(SOURCE_BYTES - 64'd1);
    localparam logic [PW:0]   NBYTES = (PW+1)'(SOURCE_BYTES);
    localparam int unsigned FW = ktl_pkg::FW;

    function automatic logic [PW-1:0] span(input logic [PW-1:0] e, input logic [PW-1:0] s);
        logic [PW:0] d;
        d = {1'b0, e} - {1'b0, s};
        if (e < s) begin
            d = d + NBYTES;
        end
        return d[PW-1:0];
    endfunction

    // lexer state
    logic [1:0]    r_mode, n_mode;
    logic [2:0]    r_prog, n_prog;
    logic [PW-1:0] r_pos, n_pos;
    logic [FW-1:0] r_line, n_line;
    logic [FW-1:0] r_col, n_col;
    logic [PW-1:0] r_pstart, n_pstart;
    logic [FW-1:0] r_pline, n_pline;
    logic [FW-1:0] r_pcol, n_pcol;
    logic          r_stop, n_stop;

    // result queue
    ktl_pkg::t_result r_q [4];
    logic [1:0]       r_head, r_tail;
    logic [2:0]       r_count, n_count;

    logic             accept, pop, used;
    logic [7:0]       c;
    logic             e0_v, e1_v, e2_v, a_v, b_v;
    ktl_pkg::t_result e0, e1, e2, res_a, res_b;
    logic [PW-1:0]    sp_cur, sp_str;
    logic [3:0]       sym;
    logic [1:0]       push_n;

    assign c      = i_source_byte;
    assign accept = i_valid && o_ready;
    assign pop    = o_valid && i_ready;
    assign o_ready = (r_count <= 3'd2);

    assign sp_cur = span(r_pos, r_pstart);
    assign sp_str = (sp_cur == '0) ? LAST : sp_cur - PW'(1);
    assign sym    = ktl_pkg::sym_class(c);

    always_comb begin
        n_mode   = r_mode;
        n_prog   = r_prog;
        n_pos    = r_pos;
        n_line   = r_line;
        n_col    = r_col;
        n_pstart = r_pstart;
        n_pline  = r_pline;
        n_pcol   = r_pcol;
        n_stop   = r_stop;
        used     = 1'b0;
        e0_v     = 1'b0;
        e1_v     = 1'b0;
        e2_v     = 1'b0;
        e0       = ktl_pkg::make_result(ktl_pkg::CL_IDENT, r_pline, r_pcol,
                                        FW'(r_pstart), FW'(sp_cur));
        e1       = ktl_pkg::make_result(sym, r_line, r_col, FW'(r_pos), FW'(1));
        e2       = ktl_pkg::make_result(ktl_pkg::CL_IDENT, r_pline, r_pcol,
                                        FW'(r_pstart), FW'(1));

        if (!r_stop) begin
            case (r_mode)
                ktl_pkg::MODE_IDENT: begin
                    if (ktl_pkg::is_letter(c)) begin
                        used   = 1'b1;
                        n_prog = ktl_pkg::KW_NONE;
                        if (r_prog == ktl_pkg::KW_F) begin
                            if (c == ktl_pkg::CH_N) begin
                                e0_v   = 1'b1;
                                e0     = ktl_pkg::make_result(ktl_pkg::CL_FN, r_pline, r_pcol,
                                                              FW'(r_pstart), FW'(2));
                                n_mode = ktl_pkg::MODE_IDLE;
                            end
                        end else if (r_prog >= ktl_pkg::KW_R && r_prog <= ktl_pkg::KW_RETU_R) begin
                            if (c == ktl_pkg::kw_char(r_prog)) begin
                                if (r_prog == ktl_pkg::KW_RETU_R) begin
                                    e0_v   = 1'b1;
                                    e0     = ktl_pkg::make_result(ktl_pkg::CL_RETURN, r_pline,
                                                                  r_pcol, FW'(r_pstart), FW'(6));
                                    n_mode = ktl_pkg::MODE_IDLE;
                                end else begin
                                    n_prog = r_prog + 3'd1;
                                end
                            end
                        end
                    end else begin
                        e0_v   = 1'b1;
                        n_mode = ktl_pkg::MODE_IDLE;
                        n_prog = ktl_pkg::KW_NONE;
                    end
                end
                ktl_pkg::MODE_NUM: begin
                    if (ktl_pkg::is_digit(c)) begin
                        used = 1'b1;
                    end else begin
                        e0_v   = 1'b1;
                        e0.token_class = ktl_pkg::CL_NUMBER;
                        n_mode = ktl_pkg::MODE_IDLE;
                    end
                end
                ktl_pkg::MODE_STR: begin
                    used = 1'b1;
                    if (c == ktl_pkg::CH_QUOTE) begin
                        e0_v   = 1'b1;
                        e0     = ktl_pkg::make_result(ktl_pkg::CL_STRING, r_pline, r_pcol,
                                     FW'((r_pstart == LAST) ? '0 : r_pstart + PW'(1)),
                                     FW'(sp_str));
                        n_mode = ktl_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = ktl_pkg::MODE_IDLE;
                end
            endcase

            if (!used && !ktl_pkg::is_space(c)) begin
                if (ktl_pkg::is_letter(c) || ktl_pkg::is_digit(c) || c == ktl_pkg::CH_QUOTE) begin
                    n_pstart = r_pos;
                    n_pline  = r_line;
                    n_pcol   = r_col;
                    n_prog   = ktl_pkg::KW_NONE;
                    if (ktl_pkg::is_letter(c)) begin
                        n_mode = ktl_pkg::MODE_IDENT;
                        if (c == ktl_pkg::CH_F) begin
                            n_prog = ktl_pkg::KW_F;
                        end else if (c == ktl_pkg::CH_R) begin
                            n_prog = ktl_pkg::KW_R;
                        end
                    end else if (ktl_pkg::is_digit(c)) begin
                        n_mode = ktl_pkg::MODE_NUM;
                    end else begin
                        n_mode = ktl_pkg::MODE_STR;
                    end
                end else begin
                    e1_v = 1'b1;
                    if (sym == ktl_pkg::CL_ERROR) begin
                        n_stop = 1'b1;
                    end
                end
            end

            n_pos = (r_pos == LAST) ? '0 : r_pos + PW'(1);
            if (c == ktl_pkg::CH_NEWLINE) begin
                if (r_line != ktl_pkg::POS_MAX) begin
                    n_line = r_line + FW'(1);
                end
                n_col = FW'(1);
            end else if (r_col != ktl_pkg::POS_MAX) begin
                n_col = r_col + FW'(1);
            end
        end

        if (i_end_of_source) begin
            if (!n_stop && n_mode != ktl_pkg::MODE_IDLE) begin
                e2_v = 1'b1;
                e2   = ktl_pkg::make_result(ktl_pkg::CL_IDENT, n_pline, n_pcol,
                                            FW'(n_pstart), FW'(span(n_pos, n_pstart)));
                if (n_mode == ktl_pkg::MODE_NUM) begin
                    e2.token_class = ktl_pkg::CL_NUMBER;
                end else if (n_mode == ktl_pkg::MODE_STR) begin
                    e2.token_class = ktl_pkg::CL_ERROR;
                end
            end
            n_mode   = ktl_pkg::MODE_IDLE;
            n_prog   = ktl_pkg::KW_NONE;
            n_pos    = '0;
            n_line   = FW'(1);
            n_col    = FW'(1);
            n_pstart = '0;
            n_pline  = FW'(1);
            n_pcol   = FW'(1);
            n_stop   = 1'b0;
        end
    end

    // pack up to two results in order
    always_comb begin
        a_v   = e0_v || e1_v || e2_v;
        b_v   = e0_v && (e1_v || e2_v);
        res_b = e1_v ? e1 : e2;
        res_a = e0_v ? e0 : res_b;
        if (b_v) begin
            res_b.last_of_item = 1'b1;
        end else begin
            res_a.last_of_item = 1'b1;
        end
        push_n = accept ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        n_count = r_count + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ktl_pkg::MODE_IDLE;
            r_prog   <= ktl_pkg::KW_NONE;
            r_pos    <= '0;
            r_line   <= FW'(1);
            r_col    <= FW'(1);
            r_pstart <= '0;
            r_pline  <= FW'(1);
            r_pcol   <= FW'(1);
            r_stop   <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_prog   <= n_prog;
                r_pos    <= n_pos;
                r_line   <= n_line;
                r_col    <= n_col;
                r_pstart <= n_pstart;
                r_pline  <= n_pline;
                r_pcol   <= n_pcol;
                r_stop   <= n_stop;
            end
            r_tail  <= r_tail + push_n;
            r_count <= n_count;
            if (pop) begin
                r_head <= r_head + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && a_v) begin
            r_q[r_tail] <= res_a;
        end
        if (accept && b_v) begin
            r_q[r_tail + 2'd1] <= res_b;
        end
    end

    assign o_valid        = (r_count != 3'd0);
    assign o_token_class  = r_q[r_head].token_class;
    assign o_token_line   = r_q[r_head].token_line;
    assign o_token_column = r_q[r_head].token_column;
    assign o_text_offset  = r_q[r_head].text_offset;
    assign o_text_length  = r_q[r_head].text_length;
    assign o_last_of_item = r_q[r_head].last_of_item;

endmodule

`default_nettype wire

[hdl/ktl_checker.sv]
// ----------------------------------------------------------------------------
// ktl_checker
// Port-level checks for the keyword token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ktl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic [7:0]  i_source_byte,
    input wire logic        i_end_of_source,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [3:0]  o_token_class,
    input wire logic [19:0] o_token_line,
    input wire logic [19:0] o_token_column,
    input wire logic [19:0] o_text_offset,
    input wire logic [19:0] o_text_length,
    input wire logic        o_last_of_item
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("token output valid straight after reset");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_class <= ktl_pkg::CL_ERROR))
        else $error("token class out of range");

    a_position_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_line != 20'd0) && (o_token_column != 20'd0))
        else $error("token line or column is zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_class)
            && $stable(o_text_offset) && $stable(o_text_length)
            && $stable(o_last_of_item))
        else $error("stalled token transfer changed");

    a_source_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_source_byte)
            && $stable(i_end_of_source))
        else $error("stalled source transfer changed");

endmodule

bind keyword_token_lexer ktl_checker u_ktl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .i_source_byte   (i_source_byte),
    .i_end_of_source (i_end_of_source),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_token_class   (o_token_class),
    .o_token_line    (o_token_line),
    .o_token_column  (o_token_column),
    .o_text_offset   (o_text_offset),
    .o_text_length   (o_text_length),
    .o_last_of_item  (o_last_of_item)
);

`default_nettype wire
